[hdl/rls_pkg.sv]
`default_nettype none

package rls_pkg;

   localparam int FIELD_W = 10;
   localparam int AXES = 3;
   localparam int LENGTH_LIMIT_DEF = 1023;
   localparam logic [FIELD_W-1:0] LIMIT_RESET = 10'd1023;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CLEAR = 2'd0;
   localparam opcode_type OP_ADD   = 2'd1;
   localparam opcode_type OP_QUERY = 2'd2;
   localparam opcode_type OP_NOP   = 2'd3;

   localparam int CSR_ADDR_W = 4;
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_LIMIT_X = 2'd0;
   localparam reg_index_type REG_LIMIT_Y = 2'd1;
   localparam reg_index_type REG_LIMIT_Z = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       step;
      opcode_type op;
      logic       publish;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/rls_ctrl.sv]
`default_nettype none

module rls_ctrl #(
   parameter int LENGTH_LIMIT = rls_pkg::LENGTH_LIMIT_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire rls_pkg::opcode_type                  req_opcode,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output rls_pkg::cmd_type                          cmd,
   output logic [$clog2(LENGTH_LIMIT+1)-1:0]         cmd_idx
);

   localparam int ADDR_W = $clog2(LENGTH_LIMIT + 1);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LENGTH_LIMIT);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   rls_pkg::opcode_type op_ff, op_in;
   logic                reply_ff, reply_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                publish;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign publish   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load    = accept;
   assign cmd.step    = (state_ff == ST_SWEEP);
   assign cmd.op      = op_ff;
   assign cmd.publish = publish;
   assign cmd_idx     = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      reply_in = reply_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               reply_in = 1'b1;
               idx_in   = LAST_IDX;
               state_in = (req_opcode == rls_pkg::OP_NOP) ? ST_DONE : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // walk entries from the top down to zero
            if (idx_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff - ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            // last write of the sweep lands here; reset sweep gives no beat
            state_in = reply_ff ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            if (publish) begin
               state_in = ST_IDLE;
               reply_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         idx_ff       <= LAST_IDX;
         op_ff        <= rls_pkg::OP_CLEAR;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         op_ff        <= op_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rls_dpath.sv]
`default_nettype none

module rls_dpath #(
   parameter int LENGTH_LIMIT = rls_pkg::LENGTH_LIMIT_DEF
) (
   input  wire logic                                                clock,
   input  wire logic                                                reset,
   input  wire rls_pkg::cmd_type                                    cmd,
   input  wire logic [$clog2(LENGTH_LIMIT+1)-1:0]                   cmd_idx,
   input  wire logic [rls_pkg::AXES-1:0][rls_pkg::FIELD_W-1:0]      req_lens,
   input  wire logic                                                req_last,
   input  wire logic [rls_pkg::FIELD_W-1:0]                         req_pos,
   input  wire logic [rls_pkg::AXES-1:0][rls_pkg::FIELD_W-1:0]      limits,
   output logic [rls_pkg::AXES-1:0][rls_pkg::FIELD_W-1:0]           reach
);

   localparam int DEPTH  = LENGTH_LIMIT + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FW     = rls_pkg::FIELD_W;
   localparam int CMP_W  = (ADDR_W > FW) ? ADDR_W : FW;
   localparam logic [CMP_W-1:0] LIMIT_MAX = CMP_W'(LENGTH_LIMIT);

   logic [rls_pkg::AXES-1:0][FW-1:0] len_ff;
   logic                             last_ff;
   logic [FW-1:0]                    pos_ff;

   logic                             s1_valid_ff;
   rls_pkg::opcode_type              s1_op_ff;
   logic [ADDR_W-1:0]                s1_idx_ff;
   logic [rls_pkg::AXES-1:0]         s1_active_ff;

   logic [rls_pkg::AXES-1:0]         reach_rd_ff;
   logic [rls_pkg::AXES-1:0]         pend_rd_ff;
   logic [rls_pkg::AXES-1:0]         found_ff;
   logic [rls_pkg::AXES-1:0][FW-1:0] work_ff;
   logic [rls_pkg::AXES-1:0][FW-1:0] out_ff;

   logic [CMP_W-1:0]                 idx_c;
   logic [CMP_W-1:0]                 s1_idx_c;
   logic                             s1_is_clear;
   logic                             s1_is_add;
   logic                             s1_is_query;

   assign idx_c       = CMP_W'(cmd_idx);
   assign s1_idx_c    = CMP_W'(s1_idx_ff);
   assign s1_is_clear = s1_valid_ff && (s1_op_ff == rls_pkg::OP_CLEAR);
   assign s1_is_add   = s1_valid_ff && (s1_op_ff == rls_pkg::OP_ADD);
   assign s1_is_query = s1_valid_ff && (s1_op_ff == rls_pkg::OP_QUERY);
   assign reach       = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff  <= req_lens;
         last_ff <= req_last;
         pos_ff  <= req_pos;
      end
      s1_op_ff  <= cmd.op;
      s1_idx_ff <= cmd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.step;
      end
   end

   for (genvar a = 0; a < rls_pkg::AXES; a++) begin : g_axis
      logic              reach_mem [DEPTH];
      logic              pend_mem  [DEPTH];
      logic [CMP_W-1:0]  lim_c;
      logic [CMP_W-1:0]  lim_eff;
      logic [CMP_W-1:0]  pos_c;
      logic [CMP_W-1:0]  qry_top;
      logic [CMP_W-1:0]  len_c;
      logic [CMP_W-1:0]  diff_c;
      logic              active;
      logic [ADDR_W-1:0] reach_addr;
      logic              pend_new;
      logic              reach_we;
      logic              pend_we;
      logic              wr_data;
      logic              hit;

      assign lim_c   = CMP_W'(limits[a]);
      assign lim_eff = (lim_c > LIMIT_MAX) ? LIMIT_MAX : lim_c;
      assign pos_c   = CMP_W'(pos_ff);
      assign qry_top = (pos_c > lim_eff) ? lim_eff : pos_c;
      assign len_c   = CMP_W'(len_ff[a]);
      assign diff_c  = idx_c - len_c;

      // entry v takes reachable[v - len] when len <= v <= limit
      assign active = (idx_c >= len_c) && (idx_c <= lim_eff);
      assign reach_addr = (cmd.op == rls_pkg::OP_ADD && active) ?
                          diff_c[ADDR_W-1:0] : cmd_idx;

      // descending walk: reach[v - len] is read before entry v gets its commit
      assign pend_new = pend_rd_ff[a] | (s1_active_ff[a] & reach_rd_ff[a]);
      assign wr_data  = s1_is_clear ? (s1_idx_ff == '0) : pend_new;
      assign pend_we  = s1_is_clear || s1_is_add;
      assign reach_we = s1_is_clear || (s1_is_add && last_ff);
      assign hit      = s1_is_query && reach_rd_ff[a] && !found_ff[a] &&
                        (s1_idx_c <= qry_top);

      always_ff @(posedge clock) begin
         if (cmd.step) begin
            reach_rd_ff[a] <= reach_mem[reach_addr];
         end
         if (reach_we) begin
            reach_mem[s1_idx_ff] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.step) begin
            pend_rd_ff[a] <= pend_mem[cmd_idx];
         end
         if (pend_we) begin
            pend_mem[s1_idx_ff] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         s1_active_ff[a] <= active;
         if (cmd.load) begin
            work_ff[a] <= '0;
         end else if (hit) begin
            work_ff[a] <= s1_idx_c[FW-1:0];
         end
         if (cmd.publish) begin
            out_ff[a] <= work_ff[a];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            found_ff[a] <= 1'b0;
         end else if (cmd.load) begin
            found_ff[a] <= 1'b0;
         end else if (hit) begin
            found_ff[a] <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/reachable_length_subset_sum_core.sv]
`default_nettype none

// channel   direction  handshake               beat contents
// req       in         req_valid / req_stall   opcode, len_x/y/z, last_rotation, position
// rsp       out        rsp_valid / rsp_stall   reach_x, reach_y, reach_z
// csr       in/out     apb write, pready = 1   limit_x, limit_y, limit_z at 0x0, 0x4, 0x8
//
// clear, add and query each go from accept to result through one sweep over the table
// from the top entry down (one read per cycle per axis), then drain and publish;
// opcode three skips the sweep and goes straight to publish.
// after reset a clearing pass runs with req_stall high.
// one item is in flight at a time; the next one is taken while a result waits on
// rsp_stall, but that one's result waits until the held beat is taken.

module reachable_length_subset_sum_core #(
   parameter int LENGTH_LIMIT = rls_pkg::LENGTH_LIMIT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_opcode,
   input  wire logic [rls_pkg::FIELD_W-1:0]           req_len_x,
   input  wire logic [rls_pkg::FIELD_W-1:0]           req_len_y,
   input  wire logic [rls_pkg::FIELD_W-1:0]           req_len_z,
   input  wire logic                                  req_last_rotation,
   input  wire logic [rls_pkg::FIELD_W-1:0]           req_position,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [rls_pkg::FIELD_W-1:0]                rsp_reach_x,
   output logic [rls_pkg::FIELD_W-1:0]                rsp_reach_y,
   output logic [rls_pkg::FIELD_W-1:0]                rsp_reach_z,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rls_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   output logic [31:0]                                csr_prdata,
   output logic                                       csr_pready
);

   localparam int ADDR_W = $clog2(LENGTH_LIMIT + 1);
   localparam int FW     = rls_pkg::FIELD_W;

   logic [FW-1:0]                        limit_x_ff, limit_y_ff, limit_z_ff;
   logic                                 csr_write;
   rls_pkg::reg_index_type               csr_index;
   rls_pkg::cmd_type                     cmd;
   logic [ADDR_W-1:0]                    cmd_idx;
   logic [rls_pkg::AXES-1:0][FW-1:0]     lens;
   logic [rls_pkg::AXES-1:0][FW-1:0]     limits;
   logic [rls_pkg::AXES-1:0][FW-1:0]     reach;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff <= rls_pkg::LIMIT_RESET;
         limit_y_ff <= rls_pkg::LIMIT_RESET;
         limit_z_ff <= rls_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rls_pkg::REG_LIMIT_X: limit_x_ff <= csr_pwdata[FW-1:0];
            rls_pkg::REG_LIMIT_Y: limit_y_ff <= csr_pwdata[FW-1:0];
            rls_pkg::REG_LIMIT_Z: limit_z_ff <= csr_pwdata[FW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rls_pkg::REG_LIMIT_X: csr_prdata = {{(32-FW){1'b0}}, limit_x_ff};
         rls_pkg::REG_LIMIT_Y: csr_prdata = {{(32-FW){1'b0}}, limit_y_ff};
         rls_pkg::REG_LIMIT_Z: csr_prdata = {{(32-FW){1'b0}}, limit_z_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign lens   = {req_len_z, req_len_y, req_len_x};
   assign limits = {limit_z_ff, limit_y_ff, limit_x_ff};

   assign rsp_reach_x = reach[0];
   assign rsp_reach_y = reach[1];
   assign rsp_reach_z = reach[2];

   rls_ctrl #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .cmd_idx    (cmd_idx)
   );

   rls_dpath #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .req_lens (lens),
      .req_last (req_last_rotation),
      .req_pos  (req_position),
      .limits   (limits),
      .reach    (reach)
   );

   // the clearing pass holds off input right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not held off after reset");

   // an accepted item keeps the block busy on the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after accept");

   // a result is published only from the busy side of the sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

`default_nettype wire

[test/tb_reachable_length_subset_sum_core.sv]
`timescale 1ns / 1ps

module tb_reachable_length_subset_sum_core;

   localparam int FW          = rls_pkg::FIELD_W;
   localparam int AXES        = rls_pkg::AXES;
   localparam int LEN_LIM     = rls_pkg::LENGTH_LIMIT_DEF;
   localparam int ITEM_CYCLES = LEN_LIM + 4;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [FW-1:0] x;
      logic [FW-1:0] y;
      logic [FW-1:0] z;
   } reach_triple_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_opcode = rls_pkg::OP_NOP;
   logic [FW-1:0]                  req_len_x = '0;
   logic [FW-1:0]                  req_len_y = '0;
   logic [FW-1:0]                  req_len_z = '0;
   logic                           req_last_rotation = 1'b0;
   logic [FW-1:0]                  req_position = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b1;
   logic [FW-1:0]                  rsp_reach_x;
   logic [FW-1:0]                  rsp_reach_y;
   logic [FW-1:0]                  rsp_reach_z;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [rls_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   // predictor state: committed and working reachability per axis
   bit            reach_tbl [AXES][LEN_LIM+1];
   bit            pend_tbl  [AXES][LEN_LIM+1];
   logic [FW-1:0] limit_q   [AXES];

   reach_triple_type expected_reach [$];

   int unsigned send_idle = 26;
   int unsigned recv_idle = 68;
   int          cycles = 0;
   int          mismatches = 0;
   int          n_clear = 0;
   int          n_add = 0;
   int          n_commit = 0;
   int          n_query = 0;
   int          n_nop = 0;
   int          settings_count = 1;

   reachable_length_subset_sum_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_len_x         (req_len_x),
      .req_len_y         (req_len_y),
      .req_len_z         (req_len_z),
      .req_last_rotation (req_last_rotation),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reach_x       (rsp_reach_x),
      .rsp_reach_y       (rsp_reach_y),
      .rsp_reach_z       (rsp_reach_z),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_reach.size());
         $display("tb_reachable_length_subset_sum_core NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   function automatic logic [FW-1:0] rand_field(input int unsigned hi, input int unsigned lo);
      return FW'($urandom_range(hi, lo));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic void reset_tables();
      for (int a = 0; a < AXES; a++) begin
         for (int v = 0; v <= LEN_LIM; v++) begin
            reach_tbl[a][v] = (v == 0);
            pend_tbl[a][v]  = (v == 0);
         end
      end
   endfunction

   function automatic int eff_limit(int a);
      return (int'(limit_q[a]) > LEN_LIM) ? LEN_LIM : int'(limit_q[a]);
   endfunction

   function automatic reach_triple_type predict_reach(input rls_pkg::opcode_type op,
                                                      input logic [FW-1:0] lx,
                                                      input logic [FW-1:0] ly,
                                                      input logic [FW-1:0] lz,
                                                      input logic last,
                                                      input logic [FW-1:0] pos);
      int               lens [AXES];
      int               found [AXES];
      int               lim;
      int               v;
      reach_triple_type r;
      lens[0] = lx;
      lens[1] = ly;
      lens[2] = lz;
      found = '{0, 0, 0};
      case (op)
         rls_pkg::OP_CLEAR: reset_tables();
         rls_pkg::OP_ADD: begin
            for (int a = 0; a < AXES; a++) begin
               lim = eff_limit(a);
               if (lens[a] <= lim) begin
                  for (v = lens[a]; v <= lim; v++) begin
                     if (reach_tbl[a][v - lens[a]]) pend_tbl[a][v] = 1'b1;
                  end
               end
            end
            // commit copies the whole table, entries above the limit too
            if (last) reach_tbl = pend_tbl;
         end
         rls_pkg::OP_QUERY: begin
            for (int a = 0; a < AXES; a++) begin
               lim = eff_limit(a);
               v = (int'(pos) > lim) ? lim : int'(pos);
               while (v > 0 && !reach_tbl[a][v]) v--;
               found[a] = v;
            end
         end
         default: ;
      endcase
      r.x = FW'(found[0]);
      r.y = FW'(found[1]);
      r.z = FW'(found[2]);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   always @(negedge clock) begin
      reach_triple_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reach.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected (%0d %0d %0d)",
                                      rsp_reach_x, rsp_reach_y, rsp_reach_z));
         end else begin
            want = expected_reach.pop_front();
            if (rsp_reach_x !== want.x)
               report_mismatch($sformatf("reach_x got %0d want %0d", rsp_reach_x, want.x));
            if (rsp_reach_y !== want.y)
               report_mismatch($sformatf("reach_y got %0d want %0d", rsp_reach_y, want.y));
            if (rsp_reach_z !== want.z)
               report_mismatch($sformatf("reach_z got %0d want %0d", rsp_reach_z, want.z));
         end
      end
   end

   // called right after a rising edge; leaves valid high on return
   task automatic send_item(input rls_pkg::opcode_type op,
                            input logic [FW-1:0] lx,
                            input logic [FW-1:0] ly,
                            input logic [FW-1:0] lz,
                            input logic last,
                            input logic [FW-1:0] pos);
      bit took;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_len_x         <= lx;
      req_len_y         <= ly;
      req_len_z         <= lz;
      req_last_rotation <= last;
      req_position      <= pos;
      do begin
         @(negedge clock);
         took = req_valid && !req_stall;
         @(posedge clock);
      end while (!took);
      expected_reach.insert(expected_reach.size(),
                            predict_reach(op, lx, ly, lz, last, pos));
      case (op)
         rls_pkg::OP_CLEAR: n_clear++;
         rls_pkg::OP_ADD: begin
            n_add++;
            if (last) n_commit++;
         end
         rls_pkg::OP_QUERY: n_query++;
         default: n_nop++;
      endcase
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_reach.size() != 0) @(posedge clock);
   endtask

   // back-to-back writes keep psel high; the caller closes the transfer
   task automatic csr_write(input rls_pkg::reg_index_type idx, input logic [FW-1:0] value);
      logic [31:0] word;
      bit          done;
      word = $urandom();
      word[FW-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end while (!done);
      limit_q[idx] = value;
   endtask

   task automatic set_limits(input logic [FW-1:0] lx,
                             input logic [FW-1:0] ly,
                             input logic [FW-1:0] lz);
      wait_drain();
      csr_write(rls_pkg::REG_LIMIT_X, lx);
      csr_write(rls_pkg::REG_LIMIT_Y, ly);
      csr_write(rls_pkg::REG_LIMIT_Z, lz);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [FW-1:0] clamp_len(input int v);
      if (v < 0) return '0;
      if (v > LEN_LIM) return FW'(LEN_LIM);
      return FW'(v);
   endfunction

   function automatic logic [FW-1:0] pick_len(input int a);
      case ($urandom_range(9))
         0: return '0;
         1, 2: return rand_field(LEN_LIM, 0);
         3: return clamp_len(eff_limit(a) + int'($urandom_range(4, 0)) - 2);
         default: return rand_field(64, 4);
      endcase
   endfunction

   function automatic logic [FW-1:0] pick_pos();
      case ($urandom_range(2))
         0: return rand_field(LEN_LIM, 0);
         1: return rand_field(200, 0);
         default: return clamp_len(eff_limit(int'($urandom_range(2))) +
                                   int'($urandom_range(6, 0)) - 3);
      endcase
   endfunction

   task automatic test_basic_ops();
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      send_item(rls_pkg::OP_ADD, 10'd0, 10'd0, 10'd0, 1'b1, 10'd0);
      send_item(rls_pkg::OP_ADD, 10'd100, 10'd200, 10'd1023, 1'b0, 10'd0);
      // pending only, queries still see the committed table
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      send_item(rls_pkg::OP_ADD, 10'd50, 10'd1, 10'd7, 1'b1, 10'd0);
      send_item(rls_pkg::OP_QUERY, 10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd99);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0);
      send_item(rls_pkg::OP_NOP, 10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023);
      send_item(rls_pkg::OP_ADD, 10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      send_item(rls_pkg::OP_CLEAR, 10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
   endtask

   task automatic test_limit_edges();
      set_limits(10'd0, 10'd1023, 10'd20);
      // z box longer than its limit leaves z untouched
      send_item(rls_pkg::OP_ADD, 10'd0, 10'd5, 10'd25, 1'b1, 10'd0);
      send_item(rls_pkg::OP_ADD, 10'd1, 10'd5, 10'd20, 1'b1, 10'd0);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd7);
      // lower limits without clear, then raise them again
      set_limits(10'd0, 10'd0, 10'd5);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      set_limits(10'd1023, 10'd1023, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd1023);
      send_item(rls_pkg::OP_QUERY, 10'd0, 10'd0, 10'd0, 1'b0, 10'd20);
   endtask

   task automatic run_random(input int n);
      int            sent;
      int            k;
      int unsigned   sel;
      bit            broken;
      logic [FW-1:0] dims [AXES];
      logic [FW-1:0] lx;
      logic [FW-1:0] ly;
      logic [FW-1:0] lz;
      sent = 0;
      while (sent < n) begin
         sel = $urandom_range(99);
         if (sel < 5) begin
            send_item(rls_pkg::OP_CLEAR, rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0),
                      rand_field(LEN_LIM, 0), rand_bit(), rand_field(LEN_LIM, 0));
            sent++;
         end else if (sel < 55) begin
            // one copy: rotations of one box, commit on the last unless broken
            for (int a = 0; a < AXES; a++) dims[a] = pick_len(a);
            k = $urandom_range(6, 1);
            broken = ($urandom_range(9) == 0);
            for (int r = 0; r < k; r++) begin
               lx = dims[r % 3];
               ly = dims[(r + 1) % 3];
               lz = dims[(r + 2) % 3];
               if (r >= 3) begin
                  ly = dims[(r + 2) % 3];
                  lz = dims[(r + 1) % 3];
               end
               send_item(rls_pkg::OP_ADD, lx, ly, lz, (r == k - 1) && !broken,
                         rand_field(LEN_LIM, 0));
               sent++;
            end
         end else if (sel < 92) begin
            send_item(rls_pkg::OP_QUERY, rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0),
                      rand_field(LEN_LIM, 0), rand_bit(), pick_pos());
            sent++;
         end else if (sel < 96) begin
            send_item(rls_pkg::OP_NOP, rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0),
                      rand_field(LEN_LIM, 0), rand_bit(), rand_field(LEN_LIM, 0));
            sent++;
         end else begin
            send_item(rls_pkg::OP_ADD, rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0),
                      rand_field(LEN_LIM, 0), rand_bit(), rand_field(LEN_LIM, 0));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      send_idle = 26;
      recv_idle = 68;
      set_limits(10'd1023, 10'd1023, 10'd1023);
      run_random(95);
      set_limits(rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0));
      run_random(95);
      send_idle = 68;
      recv_idle = 26;
      set_limits(10'd0, 10'd1023, 10'd15);
      run_random(95);
      set_limits(rand_field(200, 15), rand_field(200, 15), rand_field(200, 15));
      run_random(95);
      send_idle = 0;
      recv_idle = 0;
      set_limits(10'd1023, 10'd0, 10'd512);
      run_random(95);
      set_limits(rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0), rand_field(LEN_LIM, 0));
      run_random(85);
   endtask

   initial begin
      for (int a = 0; a < AXES; a++) limit_q[a] = rls_pkg::LIMIT_RESET;
      reset_tables();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_limit_edges();
      test_random_traffic();
      wait_drain();
      repeat (ITEM_CYCLES + 8) @(posedge clock);
      $display("covered %0d clears, %0d adds (%0d committing), %0d queries, %0d no-ops",
               n_clear, n_add, n_commit, n_query, n_nop);
      $display("over %0d limit settings and three idle mixes, %0d mismatches",
               settings_count, mismatches);
      if (mismatches == 0) begin
         $display("tb_reachable_length_subset_sum_core OK");
      end else begin
         $display("tb_reachable_length_subset_sum_core NOT OK");
      end
      $finish;
   end

endmodule
